// ----- sv/hps_pkg.sv -----
// Shared types and constants for the host power sequencer.
package hps_pkg;

  localparam int REMOTE_CODE_W = 32;
  localparam int CFG_TICKS_W   = 16;
  localparam int CFG_INDEX_W   = 3;

  localparam logic [CFG_TICKS_W-1:0] SHUTDOWN_TICKS_RESET = 16'd1000;
  localparam logic [CFG_TICKS_W-1:0] REBOOT_TICKS_RESET   = 16'd5000;
  localparam logic [CFG_TICKS_W-1:0] PROGRAM_TICKS_RESET  = 16'd15000;

  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_SHORT_PRESS = 3'd1,
    KIND_LONG_PRESS  = 3'd2,
    KIND_REMOTE      = 3'd3,
    KIND_FEEDBACK    = 3'd4,
    KIND_LED_DONE    = 3'd5,
    KIND_RECORD      = 3'd6,
    KIND_UNUSED      = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_BOOTING  = 3'd1,
    MODE_ON       = 3'd2,
    MODE_SHUTDOWN = 3'd3,
    MODE_REBOOT   = 3'd4,
    MODE_PROG     = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_ON   = 2'd1,
    STEP_OFF  = 2'd2
  } step_t;

  typedef enum logic [2:0] {
    LED_DARK       = 3'd0,
    LED_LIT        = 3'd1,
    LED_SLOW_BLINK = 3'd2,
    LED_FAST_BLINK = 3'd3,
    LED_ONE_BLINK  = 3'd4,
    LED_TWO_BLINKS = 3'd5
  } led_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FORCE_OFF_ON_HOLD = 3'd0,
    REG_LED_DISABLED      = 3'd1,
    REG_LED_FADE_STYLE    = 3'd2,
    REG_LED_INVERTED      = 3'd3,
    REG_SHUTDOWN_TICKS    = 3'd4,
    REG_REBOOT_TICKS      = 3'd5,
    REG_PROGRAM_TICKS     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                     force_off_on_hold;
    logic                     led_disabled;
    logic                     led_fade_style;
    logic                     led_inverted;
    logic [CFG_TICKS_W-1:0]   shutdown_trigger_ticks;
    logic [CFG_TICKS_W-1:0]   reboot_trigger_ticks;
    logic [CFG_TICKS_W-1:0]   program_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [REMOTE_CODE_W-1:0] remote_code;
    logic                     remote_repeat;
    logic [7:0]               pulse_count;
    logic                     feedback_level;
  } event_t;

  typedef struct packed {
    logic       watch_level;
    logic       led_fade;
    logic [2:0] led_mode;
    logic [1:0] learn_step;
    logic [2:0] main_mode;
    logic       trigger_line;
    logic       power_enable;
  } result_t;

endpackage

// ----- sv/hps_cfg.sv -----
// Configuration register file for the host power sequencer.
module hps_cfg
  import hps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_TICKS_W-1:0] cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.force_off_on_hold      <= 1'b0;
      cfg.led_disabled           <= 1'b0;
      cfg.led_fade_style         <= 1'b0;
      cfg.led_inverted           <= 1'b0;
      cfg.shutdown_trigger_ticks <= SHUTDOWN_TICKS_RESET;
      cfg.reboot_trigger_ticks   <= REBOOT_TICKS_RESET;
      cfg.program_timeout_ticks  <= PROGRAM_TICKS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FORCE_OFF_ON_HOLD: cfg.force_off_on_hold      <= cfg_data[0];
        REG_LED_DISABLED:      cfg.led_disabled           <= cfg_data[0];
        REG_LED_FADE_STYLE:    cfg.led_fade_style         <= cfg_data[0];
        REG_LED_INVERTED:      cfg.led_inverted           <= cfg_data[0];
        REG_SHUTDOWN_TICKS:    cfg.shutdown_trigger_ticks <= cfg_data;
        REG_REBOOT_TICKS:      cfg.reboot_trigger_ticks   <= cfg_data;
        REG_PROGRAM_TICKS:     cfg.program_timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/hps_ctrl.sv -----
// Sequencer state, event handling and result decode.
module hps_ctrl
  import hps_pkg::*;
#(
  parameter int CODE_BITS  = 32,
  parameter int TIMER_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  event_t  ev,
  input  cfg_t    cfg,
  output result_t result
);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  mode_t                 mode_reg, mode_reg_next;
  mode_t                 saved_mode, saved_mode_next;
  step_t                 step_reg, step_reg_next;
  logic                  code_changing, code_changing_next;
  logic [CODE_BITS-1:0]  learned_on_code, learned_on_code_next;
  logic [CODE_BITS-1:0]  learned_off_code, learned_off_code_next;
  logic [TIMER_BITS-1:0] trigger_remaining, trigger_remaining_next;
  logic                  trigger_high, trigger_high_next;
  logic [TIMER_BITS-1:0] watchdog_remaining, watchdog_remaining_next;
  logic                  watchdog_running, watchdog_running_next;
  logic                  watch_level_reg, watch_level_reg_next;

  logic [CODE_BITS-1:0]  code_in;
  logic [TIMER_BITS-1:0] shutdown_load, reboot_load, program_load;
  led_t                  led_next;

  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_TICKS_W-1:0] v);
    logic [TIMER_BITS-1:0] r;
    if (32'(v) > 32'(TIMER_MAX)) r = TIMER_MAX;
    else r = TIMER_BITS'(v);
    return r;
  endfunction

  assign code_in       = CODE_BITS'(ev.remote_code);
  assign shutdown_load = timer_load(cfg.shutdown_trigger_ticks);
  assign reboot_load   = timer_load(cfg.reboot_trigger_ticks);
  assign program_load  = timer_load(cfg.program_timeout_ticks);

  // next state
  always_comb begin
    mode_reg_next           = mode_reg;
    saved_mode_next         = saved_mode;
    step_reg_next           = step_reg;
    code_changing_next      = code_changing;
    learned_on_code_next    = learned_on_code;
    learned_off_code_next   = learned_off_code;
    trigger_remaining_next  = trigger_remaining;
    trigger_high_next       = trigger_high;
    watchdog_remaining_next = watchdog_remaining;
    watchdog_running_next   = watchdog_running;
    watch_level_reg_next    = watch_level_reg;
    if (advance) begin
      unique case (kind_t'(ev.kind))
        KIND_TICK: begin
          if (trigger_high) begin
            if (trigger_remaining <= TIMER_BITS'(1)) begin
              trigger_remaining_next = '0;
              trigger_high_next      = 1'b0;
            end else begin
              trigger_remaining_next = trigger_remaining - TIMER_BITS'(1);
            end
          end
          if (watchdog_running) begin
            if (watchdog_remaining <= TIMER_BITS'(1)) begin
              mode_reg_next           = saved_mode;
              step_reg_next           = STEP_NONE;
              code_changing_next      = 1'b0;
              watchdog_running_next   = 1'b0;
              watchdog_remaining_next = '0;
            end else begin
              watchdog_remaining_next = watchdog_remaining - TIMER_BITS'(1);
            end
          end
        end
        KIND_SHORT_PRESS: begin
          if (mode_reg == MODE_OFF) begin
            mode_reg_next        = MODE_BOOTING;
            watch_level_reg_next = 1'b0;
          end else if (mode_reg == MODE_ON) begin
            mode_reg_next          = MODE_SHUTDOWN;
            watch_level_reg_next   = 1'b1;
            trigger_high_next      = 1'b1;
            trigger_remaining_next = shutdown_load;
          end else if (mode_reg == MODE_PROG) begin
            if (step_reg == STEP_ON) begin
              code_changing_next      = 1'b1;
              watchdog_running_next   = 1'b1;
              watchdog_remaining_next = program_load;
            end else if (step_reg == STEP_OFF) begin
              learned_off_code_next = learned_on_code;
              code_changing_next    = 1'b1;
            end
          end
        end
        KIND_LONG_PRESS: begin
          if (mode_reg == MODE_ON) begin
            if (!cfg.force_off_on_hold) begin
              mode_reg_next          = MODE_REBOOT;
              watch_level_reg_next   = 1'b0;
              trigger_high_next      = 1'b1;
              trigger_remaining_next = reboot_load;
            end else begin
              mode_reg_next = MODE_OFF;
            end
          end else if (mode_reg == MODE_OFF) begin
            saved_mode_next         = mode_reg;
            mode_reg_next           = MODE_PROG;
            step_reg_next           = STEP_ON;
            code_changing_next      = 1'b0;
            watchdog_running_next   = 1'b1;
            watchdog_remaining_next = program_load;
          end else if (mode_reg == MODE_PROG) begin
            mode_reg_next           = saved_mode;
            step_reg_next           = STEP_NONE;
            code_changing_next      = 1'b0;
            watchdog_running_next   = 1'b0;
            watchdog_remaining_next = '0;
          end
        end
        KIND_REMOTE: begin
          if (!ev.remote_repeat) begin
            if (mode_reg != MODE_PROG) begin
              if (code_in == learned_on_code && mode_reg == MODE_OFF) begin
                mode_reg_next        = MODE_BOOTING;
                watch_level_reg_next = 1'b0;
              end else if (code_in == learned_off_code && mode_reg == MODE_ON) begin
                mode_reg_next          = MODE_SHUTDOWN;
                watch_level_reg_next   = 1'b1;
                trigger_high_next      = 1'b1;
                trigger_remaining_next = shutdown_load;
              end
            end else if (step_reg == STEP_ON) begin
              learned_on_code_next    = code_in;
              code_changing_next      = 1'b1;
              watchdog_running_next   = 1'b1;
              watchdog_remaining_next = program_load;
            end else if (step_reg == STEP_OFF) begin
              learned_off_code_next = code_in;
              code_changing_next    = 1'b1;
            end
          end
        end
        KIND_FEEDBACK: begin
          if (ev.pulse_count != 8'd0) begin
            if (mode_reg == MODE_ON) begin
              if (ev.pulse_count == 8'd1) begin
                mode_reg_next        = MODE_SHUTDOWN;
                watch_level_reg_next = 1'b1;
              end else if (ev.pulse_count == 8'd2) begin
                mode_reg_next        = MODE_REBOOT;
                watch_level_reg_next = 1'b0;
              end
            end
          end else if (!ev.feedback_level) begin
            mode_reg_next        = MODE_ON;
            watch_level_reg_next = 1'b1;
          end else begin
            mode_reg_next        = MODE_OFF;
            watch_level_reg_next = 1'b0;
          end
        end
        KIND_LED_DONE: begin
          code_changing_next = 1'b0;
          if (step_reg == STEP_ON) begin
            step_reg_next = STEP_OFF;
          end else if (step_reg == STEP_OFF) begin
            mode_reg_next           = saved_mode;
            step_reg_next           = STEP_NONE;
            watchdog_running_next   = 1'b0;
            watchdog_remaining_next = '0;
          end
        end
        KIND_RECORD: begin
          saved_mode_next         = mode_reg;
          mode_reg_next           = MODE_PROG;
          step_reg_next           = STEP_ON;
          code_changing_next      = 1'b0;
          watchdog_running_next   = 1'b1;
          watchdog_remaining_next = program_load;
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    unique case (mode_reg_next)
      MODE_BOOTING, MODE_SHUTDOWN, MODE_REBOOT:
        led_next = cfg.led_disabled ? LED_DARK : LED_SLOW_BLINK;
      MODE_ON:
        led_next = (cfg.led_disabled || cfg.led_inverted) ? LED_DARK : LED_LIT;
      MODE_OFF:
        led_next = (!cfg.led_disabled && cfg.led_inverted) ? LED_LIT : LED_DARK;
      MODE_PROG: begin
        if (!code_changing_next) led_next = LED_FAST_BLINK;
        else if (step_reg_next == STEP_ON) led_next = LED_ONE_BLINK;
        else if (step_reg_next == STEP_OFF) led_next = LED_TWO_BLINKS;
        else led_next = LED_DARK;
      end
      default: led_next = LED_DARK;
    endcase
    result.power_enable = !(mode_reg_next == MODE_OFF || mode_reg_next == MODE_PROG);
    result.trigger_line = trigger_high_next;
    result.main_mode    = mode_reg_next;
    result.learn_step   = step_reg_next;
    result.led_mode     = led_next;
    result.led_fade     = cfg.led_fade_style;
    result.watch_level  = watch_level_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg           <= MODE_OFF;
      saved_mode         <= MODE_OFF;
      step_reg           <= STEP_NONE;
      code_changing      <= 1'b0;
      learned_on_code    <= '0;
      learned_off_code   <= '0;
      trigger_remaining  <= '0;
      trigger_high       <= 1'b0;
      watchdog_remaining <= '0;
      watchdog_running   <= 1'b0;
      watch_level_reg    <= 1'b0;
    end else begin
      mode_reg           <= mode_reg_next;
      saved_mode         <= saved_mode_next;
      step_reg           <= step_reg_next;
      code_changing      <= code_changing_next;
      learned_on_code    <= learned_on_code_next;
      learned_off_code   <= learned_off_code_next;
      trigger_remaining  <= trigger_remaining_next;
      trigger_high       <= trigger_high_next;
      watchdog_remaining <= watchdog_remaining_next;
      watchdog_running   <= watchdog_running_next;
      watch_level_reg    <= watch_level_reg_next;
    end
  end

  a_trigger_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !trigger_high |-> trigger_remaining == '0)
    else $error("trigger timer count left while idle");

  a_watchdog_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !watchdog_running |-> watchdog_remaining == '0)
    else $error("watchdog count left while stopped");

  a_changing_needs_step: assert property (@(posedge clk) disable iff (rst)
    code_changing |-> step_reg != STEP_NONE)
    else $error("code change flagged with no learn step");

endmodule

// ----- sv/host_power_sequencer_core.sv -----
// Top level of the host power sequencer: event register, control and result register.
//
//  port group  | dir | transfer when          | payload
//  s_*         | in  | s_tvalid & s_tready    | tuser kind, tdata event fields
//  m_*         | out | m_tvalid & m_tready    | tdata result fields
//  cfg_*       | in  | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// One event per cycle unless the result output stalls. The event register feeds the
// control logic, and the result register takes its result when the event advances.
// rst is synchronous; it resets state, config and valid flags, not data registers.
// A stalled result holds; an occupied event register then waits until it drains.
module host_power_sequencer_core
  import hps_pkg::*;
#(
  parameter int CODE_BITS  = 32,
  parameter int TIMER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [2:0]             s_tuser,  // kind
  // remote_code, remote_repeat, pulse_count, feedback_level, zero pad
  input  logic [47:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // power_enable, trigger_line, main_mode, learn_step, led_mode, led_fade,
  // watch_level, zero pad
  output logic [15:0]            m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_TICKS_W-1:0] cfg_data
);

  logic    ev_valid;
  event_t  ev;
  logic    advance;
  cfg_t    cfg;
  result_t result;
  result_t out_reg;

  assign advance  = ev_valid && (!m_tvalid || m_tready);
  assign s_tready = !ev_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (s_tready) begin
      ev_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ev.kind           <= s_tuser;
      ev.remote_code    <= s_tdata[31:0];
      ev.remote_repeat  <= s_tdata[32];
      ev.pulse_count    <= s_tdata[40:33];
      ev.feedback_level <= s_tdata[41];
    end
  end

  hps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hps_ctrl #(
    .CODE_BITS  (CODE_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ev      (ev),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {4'b0, out_reg};

endmodule

// ----- tb/host_power_sequencer_core_tb.sv -----
// Self-checking testbench for host_power_sequencer_core: event stream checked against a predictor.
`timescale 1ns / 1ps

module host_power_sequencer_core_tb;
  import hps_pkg::*;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [2:0]             s_tuser   = '0;  // kind
  // remote_code, remote_repeat, pulse_count, feedback_level, zero pad
  logic [47:0]            s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // power_enable, trigger_line, main_mode, learn_step, led_mode, led_fade,
  // watch_level, zero pad
  logic [15:0]            m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_TICKS_W-1:0] cfg_data  = '0;

  host_power_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted sequencer state
  mode_t       mode_q, saved_mode_q;
  step_t       step_q;
  bit          changing_q, trig_on, wd_on, watch_q;
  logic [31:0] on_code_q, off_code_q;
  logic [15:0] trig_left, wd_left;
  bit          force_off_cfg, led_off_cfg, fade_cfg, invert_cfg;
  logic [15:0] shutdown_len, reboot_len, prog_len;

  result_t expected_status[$];
  int      mismatch_count = 0;
  int      sent_count     = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[host_power_sequencer_core] ERROR");
    $finish;
  end

  function void reset_sequencer();
    force_off_cfg = 0;
    led_off_cfg   = 0;
    fade_cfg      = 0;
    invert_cfg    = 0;
    shutdown_len  = SHUTDOWN_TICKS_RESET;
    reboot_len    = REBOOT_TICKS_RESET;
    prog_len      = PROGRAM_TICKS_RESET;
    mode_q        = MODE_OFF;
    saved_mode_q  = MODE_OFF;
    step_q        = STEP_NONE;
    changing_q    = 0;
    on_code_q     = '0;
    off_code_q    = '0;
    trig_left     = '0;
    trig_on       = 0;
    wd_left       = '0;
    wd_on         = 0;
    watch_q       = 0;
  endfunction

  function void apply_setting(reg_index_t idx, logic [15:0] val);
    case (idx)
      REG_FORCE_OFF_ON_HOLD: force_off_cfg = val[0];
      REG_LED_DISABLED:      led_off_cfg   = val[0];
      REG_LED_FADE_STYLE:    fade_cfg      = val[0];
      REG_LED_INVERTED:      invert_cfg    = val[0];
      REG_SHUTDOWN_TICKS:    shutdown_len  = val;
      REG_REBOOT_TICKS:      reboot_len    = val;
      REG_PROGRAM_TICKS:     prog_len      = val;
      default: ;
    endcase
  endfunction

  function void arm_watchdog();
    wd_on   = 1;
    wd_left = prog_len;
  endfunction

  function void enter_boot();
    if (mode_q != MODE_BOOTING) begin
      mode_q  = MODE_BOOTING;
      watch_q = 0;
    end
  endfunction

  function void enter_shutdown(bit pulse);
    if (mode_q != MODE_SHUTDOWN) begin
      mode_q  = MODE_SHUTDOWN;
      watch_q = 1;
      if (pulse) begin
        trig_on   = 1;
        trig_left = shutdown_len;
      end
    end
  endfunction

  function void enter_reboot(bit pulse);
    if (mode_q != MODE_REBOOT) begin
      mode_q  = MODE_REBOOT;
      watch_q = 0;
      if (pulse) begin
        trig_on   = 1;
        trig_left = reboot_len;
      end
    end
  endfunction

  function void start_learning();
    saved_mode_q = mode_q;
    mode_q       = MODE_PROG;
    step_q       = STEP_ON;
    changing_q   = 0;
    arm_watchdog();
  endfunction

  function void stop_learning();
    mode_q     = saved_mode_q;
    step_q     = STEP_NONE;
    changing_q = 0;
    wd_on      = 0;
    wd_left    = '0;
  endfunction

  function result_t step_sequencer(event_t ev);
    result_t r;
    case (kind_t'(ev.kind))
      KIND_TICK: begin
        // trigger timer is served before the watchdog
        if (trig_on) begin
          if (trig_left <= 1) begin
            trig_left = '0;
            trig_on   = 0;
          end else begin
            trig_left = trig_left - 1'b1;
          end
        end
        if (wd_on) begin
          if (wd_left <= 1) stop_learning();
          else wd_left = wd_left - 1'b1;
        end
      end
      KIND_SHORT_PRESS: begin
        if (mode_q == MODE_OFF) begin
          enter_boot();
        end else if (mode_q == MODE_ON) begin
          enter_shutdown(1);
        end else if (mode_q == MODE_PROG) begin
          if (step_q == STEP_ON) begin
            changing_q = 1;
            arm_watchdog();
          end else if (step_q == STEP_OFF) begin
            off_code_q = on_code_q;
            changing_q = 1;
          end
        end
      end
      KIND_LONG_PRESS: begin
        if (mode_q == MODE_ON) begin
          if (!force_off_cfg) enter_reboot(1);
          else mode_q = MODE_OFF;
        end else if (mode_q == MODE_OFF) begin
          start_learning();
        end else if (mode_q == MODE_PROG) begin
          stop_learning();
        end
      end
      KIND_REMOTE: begin
        if (!ev.remote_repeat) begin
          if (mode_q != MODE_PROG) begin
            if (ev.remote_code == on_code_q && mode_q == MODE_OFF) enter_boot();
            else if (ev.remote_code == off_code_q && mode_q == MODE_ON) enter_shutdown(1);
          end else if (step_q == STEP_ON) begin
            on_code_q  = ev.remote_code;
            changing_q = 1;
            arm_watchdog();
          end else if (step_q == STEP_OFF) begin
            off_code_q = ev.remote_code;
            changing_q = 1;
          end
        end
      end
      KIND_FEEDBACK: begin
        if (ev.pulse_count != 0) begin
          if (mode_q == MODE_ON) begin
            if (ev.pulse_count == 1) enter_shutdown(0);
            else if (ev.pulse_count == 2) enter_reboot(0);
          end
        end else if (!ev.feedback_level) begin
          mode_q  = MODE_ON;
          watch_q = 1;
        end else begin
          mode_q  = MODE_OFF;
          watch_q = 0;
        end
      end
      KIND_LED_DONE: begin
        changing_q = 0;
        if (step_q == STEP_ON) step_q = STEP_OFF;
        else if (step_q == STEP_OFF) stop_learning();
      end
      KIND_RECORD: start_learning();
      default: ;
    endcase

    r.power_enable = (mode_q != MODE_OFF && mode_q != MODE_PROG);
    r.trigger_line = trig_on;
    r.main_mode    = mode_q;
    r.learn_step   = step_q;
    r.led_fade     = fade_cfg;
    r.watch_level  = watch_q;
    case (mode_q)
      MODE_BOOTING, MODE_SHUTDOWN, MODE_REBOOT:
        r.led_mode = led_off_cfg ? LED_DARK : LED_SLOW_BLINK;
      MODE_ON:  r.led_mode = (led_off_cfg || invert_cfg) ? LED_DARK : LED_LIT;
      MODE_OFF: r.led_mode = (!led_off_cfg && invert_cfg) ? LED_LIT : LED_DARK;
      MODE_PROG: begin
        if (!changing_q) r.led_mode = LED_FAST_BLINK;
        else if (step_q == STEP_ON) r.led_mode = LED_ONE_BLINK;
        else if (step_q == STEP_OFF) r.led_mode = LED_TWO_BLINKS;
        else r.led_mode = LED_DARK;
      end
      default: r.led_mode = LED_DARK;
    endcase
    return r;
  endfunction

  function string show_status(result_t r);
    return $sformatf("pwr=%0d trig=%0d mode=%0d step=%0d led=%0d fade=%0d watch=%0d",
                     r.power_enable, r.trigger_line, r.main_mode, r.learn_step,
                     r.led_mode, r.led_fade, r.watch_level);
  endfunction

  function automatic event_t make_event(kind_t k, logic [31:0] code, bit rep,
                                        logic [7:0] pulses, bit lvl);
    event_t ev;
    ev.kind           = k;
    ev.remote_code    = code;
    ev.remote_repeat  = rep;
    ev.pulse_count    = pulses;
    ev.feedback_level = lvl;
    return ev;
  endfunction

  function automatic event_t noisy_event(kind_t k);
    logic [7:0] pulses;
    case ($urandom_range(9))
      0, 1, 2, 3: pulses = 8'd0;
      4, 5:       pulses = 8'd1;
      6, 7:       pulses = 8'd2;
      8:          pulses = 8'hFF;
      default:    pulses = 8'($urandom_range(255));
    endcase
    return make_event(k, $urandom(), $urandom_range(5) == 0, pulses,
                      1'($urandom_range(1)));
  endfunction

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin : check_status
    result_t seen, want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[11:0];
      if (expected_status.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected status transfer: %s", show_status(seen));
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        if (seen !== want) begin
          if (mismatch_count < 10)
            $display("status mismatch: expected %s, got %s", show_status(want),
                     show_status(seen));
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_event(input event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.kind;
    s_tdata  <= {6'd0, ev.feedback_level, ev.pulse_count, ev.remote_repeat, ev.remote_code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_status.push_back(step_sequencer(ev));
    sent_count++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_event(noisy_event(KIND_TICK));
  endtask

  // hold the sender until every status transfer is back, then let the pipe empty
  task automatic settle_block();
    s_tvalid <= 1'b0;
    for (int i = 0; i < 5000 && expected_status.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_power_paths();
    send_event(make_event(KIND_UNUSED, 32'hFFFF_FFFF, 1, 8'hFF, 1));
    send_event(make_event(KIND_REMOTE, 32'h0, 0, 8'h0, 0));   // matches reset on code
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'hFF, 1)); // other counts ignored
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd1, 0));
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd2, 0));
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_SHORT_PRESS, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd0, 1));
  endtask

  task automatic test_code_learning();
    send_event(make_event(KIND_LONG_PRESS, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_REMOTE, 32'hFFFF_FFFF, 1, 8'd0, 0));
    send_event(make_event(KIND_REMOTE, 32'hFFFF_FFFF, 0, 8'd0, 0));
    send_event(make_event(KIND_LED_DONE, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_SHORT_PRESS, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_LED_DONE, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_REMOTE, 32'hFFFF_FFFF, 0, 8'd0, 0));
  endtask

  task automatic test_special_events();
    send_event(make_event(KIND_RECORD, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_RECORD, 32'h0, 0, 8'd0, 0));     // saved mode becomes programming
    send_event(make_event(KIND_LONG_PRESS, 32'h0, 0, 8'd0, 0)); // stays programming, no step
    send_event(make_event(KIND_SHORT_PRESS, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_LED_DONE, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd0, 0));
  endtask

  task automatic test_zero_length_timers();
    settle_block();
    write_register(REG_FORCE_OFF_ON_HOLD, 16'd1);
    write_register(REG_SHUTDOWN_TICKS, 16'd0);
    write_register(REG_PROGRAM_TICKS, 16'd0);
    send_event(make_event(KIND_SHORT_PRESS, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_RECORD, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_TICK, 32'h0, 0, 8'd0, 0));       // both timers end together
    send_event(make_event(KIND_FEEDBACK, 32'h0, 0, 8'd0, 0));
    send_event(make_event(KIND_LONG_PRESS, 32'h0, 0, 8'd0, 0)); // forced off, watch level kept
  endtask

  task automatic run_power_cycle();
    event_t ev;
    if ($urandom_range(1)) begin
      send_event(noisy_event(KIND_SHORT_PRESS));
    end else begin
      ev = noisy_event(KIND_REMOTE);
      ev.remote_code   = on_code_q;
      ev.remote_repeat = 0;
      send_event(ev);
    end
    send_ticks($urandom_range(3));
    ev = noisy_event(KIND_FEEDBACK);
    ev.pulse_count    = 0;
    ev.feedback_level = 0;
    send_event(ev);
    send_ticks($urandom_range(2));
    case ($urandom_range(4))
      0: send_event(noisy_event(KIND_SHORT_PRESS));
      1: send_event(noisy_event(KIND_LONG_PRESS));
      2: begin
        ev = noisy_event(KIND_REMOTE);
        ev.remote_code   = off_code_q;
        ev.remote_repeat = 0;
        send_event(ev);
      end
      default: begin
        ev = noisy_event(KIND_FEEDBACK);
        ev.pulse_count = 8'($urandom_range(2, 1));
        send_event(ev);
      end
    endcase
    send_ticks($urandom_range(6));
    ev = noisy_event(KIND_FEEDBACK);
    ev.pulse_count = 0;
    send_event(ev);
  endtask

  task automatic run_code_learning();
    event_t ev;
    send_event(noisy_event($urandom_range(1) ? KIND_RECORD : KIND_LONG_PRESS));
    repeat (2) begin
      send_ticks($urandom_range(3));
      if ($urandom_range(3) == 0) begin
        send_event(noisy_event(KIND_SHORT_PRESS));
      end else begin
        ev = noisy_event(KIND_REMOTE);
        ev.remote_repeat = 0;
        send_event(ev);
      end
      send_ticks($urandom_range(2));
      send_event(noisy_event(KIND_LED_DONE));
    end
  endtask

  task automatic test_random_traffic(input bit force_off, input bit led_off, input bit fade,
                                     input bit invert, input logic [15:0] shut_ticks,
                                     input logic [15:0] reboot_ticks,
                                     input logic [15:0] prog_ticks, input int n_items);
    int     first, pick;
    event_t ev;
    settle_block();
    write_register(REG_FORCE_OFF_ON_HOLD, {15'd0, force_off});
    write_register(REG_LED_DISABLED, {15'd0, led_off});
    write_register(REG_LED_FADE_STYLE, {15'd0, fade});
    write_register(REG_LED_INVERTED, {15'd0, invert});
    write_register(REG_SHUTDOWN_TICKS, shut_ticks);
    write_register(REG_REBOOT_TICKS, reboot_ticks);
    write_register(REG_PROGRAM_TICKS, prog_ticks);
    first = sent_count;
    while (sent_count - first < n_items) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        run_code_learning();
      end else if (pick < 4) begin
        run_power_cycle();
      end else begin
        repeat (3) begin
          pick = $urandom_range(99);
          ev = noisy_event(pick < 30 ? KIND_TICK : pick < 42 ? KIND_SHORT_PRESS :
                           pick < 52 ? KIND_LONG_PRESS : pick < 67 ? KIND_REMOTE :
                           pick < 82 ? KIND_FEEDBACK : pick < 90 ? KIND_LED_DONE :
                           pick < 96 ? KIND_RECORD : KIND_UNUSED);
          if (ev.kind == KIND_REMOTE) begin
            case ($urandom_range(3))
              0: ev.remote_code = on_code_q;
              1: ev.remote_code = off_code_q;
              default: ;
            endcase
          end
          send_event(ev);
        end
      end
    end
  endtask

  initial begin
    reset_sequencer();
    send_idle_pct = 34;
    recv_idle_pct = 75;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_paths();
    test_code_learning();
    test_special_events();
    test_zero_length_timers();

    test_random_traffic(0, 0, 0, 0, 16'd3, 16'd6, 16'd10, 275);
    test_random_traffic(1, 0, 1, 1, 16'd1, 16'd1, 16'd1, 275);
    send_idle_pct = 75;
    recv_idle_pct = 34;
    test_random_traffic(0, 1, 1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 275);
    test_random_traffic(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 16'($urandom_range(16, 1)),
                        16'($urandom_range(16, 1)), 16'($urandom_range(16, 1)), 275);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(1, 1, 0, 1, 16'd2, 16'd4, 16'd12, 275);
    test_random_traffic(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 16'($urandom_range(16, 1)),
                        16'($urandom_range(16, 1)), 16'($urandom_range(16, 1)), 275);

    settle_block();
    mismatch_count += expected_status.size();
    if (mismatch_count == 0) begin
      $display("[host_power_sequencer_core] OK");
    end else begin
      $display("[host_power_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hps_pkg.sv
sv/hps_cfg.sv
sv/hps_ctrl.sv
sv/host_power_sequencer_core.sv
tb/host_power_sequencer_core_tb.sv
